// ===== hw/rtl/cbf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types and constants of the cubic Bezier flattener: coordinate and
// accumulator widths, lane operation codes and the configuration map.
// ----------------------------------------------------------------------------
package cbf_pkg;

  // Width of one input coordinate, 16.16 fixed point.
  localparam int IN_W   = 32;
  // Width of a stored piece coordinate.
  localparam int CW     = 36;
  // Width of the shared adder and its temporaries.
  localparam int AW     = 40;
  // Width of one pixel delta.
  localparam int PIX_W  = 16;
  // Width of the flatness limit register.
  localparam int LIM_W  = 31;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_FLAT_LIMIT = '0;
  localparam logic [LIM_W-1:0]  FLAT_LIMIT_RST = 31'd262144;

  typedef logic signed [IN_W-1:0]  in_coord_t;
  typedef logic signed [CW-1:0]    coord_t;
  typedef logic signed [AW-1:0]    acc_t;
  typedef logic signed [PIX_W-1:0] pix_t;

  // Saturation bounds of a pixel delta.
  localparam acc_t PIX_HI = acc_t'(32767);
  localparam acc_t PIX_LO = ~PIX_HI;

  // One pending second half of a split.
  typedef struct packed {
    coord_t p1x;
    coord_t p1y;
    coord_t p2x;
    coord_t p2y;
    coord_t p3x;
    coord_t p3y;
  } stk_entry_t;

  // Step of an axis lane.
  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD,
    OP_CHECK,
    OP_PIX,
    OP_AB,
    OP_BC,
    OP_A2B,
    OP_ABC,
    OP_MID,
    OP_S1,
    OP_S2,
    OP_S3
  } lane_op_t;

  function automatic acc_t ext_coord(input coord_t v);
    ext_coord = {{(AW-CW){v[CW-1]}}, v};
  endfunction

  function automatic coord_t ext_input(input in_coord_t v);
    ext_input = {{(CW-IN_W){v[IN_W-1]}}, v};
  endfunction

  function automatic acc_t neg_limit_of(input logic [LIM_W-1:0] lim);
    acc_t pos;
    pos = {{(AW-LIM_W){1'b0}}, lim};
    neg_limit_of = -pos;
  endfunction

endpackage

// ===== hw/rtl/cubic_bezier_flattener_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_core
// Flattens one cubic Bezier curve per request into pixel deltas by midpoint
// subdivision, first half before second, with a stack of pending halves.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_stall    ctrl1_x/y, ctrl2_x/y, end_x/y
//  output    out        out_valid / out_stall  step_dx, step_dy, last_step
//  config    in         APB write/read         flat_limit at address 0
//
// Each axis has one adder. A split node takes a check, eight adder steps and
// a push, and a leaf takes a check, a rounding step and a pop; the last leaf
// of a curve has no pop. in_stall is high while a curve is in progress. A
// stalled output holds the sequencer at its rounding step. Reset empties the
// stack, drops any pending result and sets flat_limit to 262144.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_core #(
  parameter int MAX_DEPTH = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cbf_pkg::in_coord_t            ctrl1_x,
  input  cbf_pkg::in_coord_t            ctrl1_y,
  input  cbf_pkg::in_coord_t            ctrl2_x,
  input  cbf_pkg::in_coord_t            ctrl2_y,
  input  cbf_pkg::in_coord_t            end_x,
  input  cbf_pkg::in_coord_t            end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cbf_pkg::pix_t                 step_dx,
  output cbf_pkg::pix_t                 step_dy,
  output logic                          last_step,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbf_pkg::ADDR_W-1:0]    paddr,
  input  logic [cbf_pkg::DATA_W-1:0]    pwdata,
  output logic [cbf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import cbf_pkg::*;

  localparam int LW   = $clog2(MAX_DEPTH + 1);
  localparam int IDXW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PIX,
    ST_POP,
    ST_AB,
    ST_BC,
    ST_A2B,
    ST_ABC,
    ST_MID,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_PUSH
  } state_t;

  state_t            state;
  logic [LW-1:0]     stack_top;
  logic [LW-1:0]     top_m1;
  logic [LW-1:0]     cur_level;
  logic [LIM_W-1:0]  flat_limit;
  acc_t              neg_limit;
  lane_op_t          op;

  stk_entry_t        stk [MAX_DEPTH];
  logic [LW-1:0]     stk_level [MAX_DEPTH];
  logic [IDXW-1:0]   rd_idx;
  logic [IDXW-1:0]   wr_idx;
  stk_entry_t        rd_entry;

  coord_t            ldx1, ldx2, ldx3, ldy1, ldy2, ldy3;
  logic              flat_x, flat_y, leaf, out_free, cfg_wr, reg_hit;
  pix_t              pix_x, pix_y;
  coord_t            hx1, hx2, hx3, hy1, hy2, hy3;

  assign top_m1   = stack_top - {{(LW-1){1'b0}}, 1'b1};
  assign rd_idx   = top_m1[IDXW-1:0];
  assign wr_idx   = stack_top[IDXW-1:0];

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign leaf     = (cur_level == LW'(MAX_DEPTH)) || (flat_x && flat_y);

  assign reg_hit = (paddr[ADDR_W-1:2] == REG_FLAT_LIMIT);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(DATA_W-LIM_W){1'b0}}, flat_limit} : '0;

  // A new curve loads from the input ports, a pop from the stack top.
  always_comb begin
    if (state == ST_IDLE) begin
      ldx1 = ext_input(ctrl1_x);
      ldy1 = ext_input(ctrl1_y);
      ldx2 = ext_input(ctrl2_x);
      ldy2 = ext_input(ctrl2_y);
      ldx3 = ext_input(end_x);
      ldy3 = ext_input(end_y);
    end else begin
      ldx1 = rd_entry.p1x;
      ldy1 = rd_entry.p1y;
      ldx2 = rd_entry.p2x;
      ldy2 = rd_entry.p2y;
      ldx3 = rd_entry.p3x;
      ldy3 = rd_entry.p3y;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:  op = in_valid ? OP_LOAD : OP_HOLD;
      ST_CHECK: op = OP_CHECK;
      ST_PIX:   op = OP_PIX;
      ST_POP:   op = OP_LOAD;
      ST_AB:    op = OP_AB;
      ST_BC:    op = OP_BC;
      ST_A2B:   op = OP_A2B;
      ST_ABC:   op = OP_ABC;
      ST_MID:   op = OP_MID;
      ST_S1:    op = OP_S1;
      ST_S2:    op = OP_S2;
      ST_S3:    op = OP_S3;
      default:  op = OP_HOLD;
    endcase
  end

  cbf_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_x (
    .clk        (clk),
    .op         (op),
    .ld_p1      (ldx1),
    .ld_p2      (ldx2),
    .ld_p3      (ldx3),
    .flat_limit (flat_limit),
    .neg_limit  (neg_limit),
    .flat       (flat_x),
    .pix        (pix_x),
    .half_p1    (hx1),
    .half_p2    (hx2),
    .half_p3    (hx3)
  );

  cbf_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_y (
    .clk        (clk),
    .op         (op),
    .ld_p1      (ldy1),
    .ld_p2      (ldy2),
    .ld_p3      (ldy3),
    .flat_limit (flat_limit),
    .neg_limit  (neg_limit),
    .flat       (flat_y),
    .pix        (pix_y),
    .half_p1    (hy1),
    .half_p2    (hy2),
    .half_p3    (hy3)
  );

  // Stack of pending second halves. The top entry is registered ahead of a
  // pop, while the leaf before that pop is being rounded.
  always_ff @(posedge clk) begin
    if (state == ST_PUSH) begin
      stk[wr_idx].p1x   <= hx1;
      stk[wr_idx].p1y   <= hy1;
      stk[wr_idx].p2x   <= hx2;
      stk[wr_idx].p2y   <= hy2;
      stk[wr_idx].p3x   <= hx3;
      stk[wr_idx].p3y   <= hy3;
      stk_level[wr_idx] <= cur_level;
    end
    rd_entry <= stk[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      stack_top  <= '0;
      cur_level  <= '0;
      out_valid  <= 1'b0;
      flat_limit <= FLAT_LIMIT_RST;
      neg_limit  <= neg_limit_of(FLAT_LIMIT_RST);
    end else begin
      if (cfg_wr) begin
        flat_limit <= pwdata[LIM_W-1:0];
        neg_limit  <= neg_limit_of(pwdata[LIM_W-1:0]);
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            stack_top <= '0;
            cur_level <= '0;
            state     <= ST_CHECK;
          end
        end
        ST_CHECK: state <= leaf ? ST_PIX : ST_AB;
        ST_PIX: begin
          // The result waits here until the output register is free.
          if (out_free) begin
            out_valid <= 1'b1;
            step_dx   <= pix_x;
            step_dy   <= pix_y;
            last_step <= (stack_top == '0);
            state     <= (stack_top == '0) ? ST_IDLE : ST_POP;
          end
        end
        ST_POP: begin
          stack_top <= top_m1;
          cur_level <= stk_level[rd_idx];
          state     <= ST_CHECK;
        end
        ST_AB:  state <= ST_BC;
        ST_BC:  state <= ST_A2B;
        ST_A2B: state <= ST_ABC;
        ST_ABC: state <= ST_MID;
        ST_MID: state <= ST_S1;
        ST_S1:  state <= ST_S2;
        ST_S2:  state <= ST_S3;
        ST_S3: begin
          cur_level <= cur_level + {{(LW-1){1'b0}}, 1'b1};
          state     <= ST_PUSH;
        end
        ST_PUSH: begin
          stack_top <= stack_top + {{(LW-1){1'b0}}, 1'b1};
          state     <= ST_CHECK;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cbf_lane.sv =====
// ----------------------------------------------------------------------------
// cbf_lane
// One axis of the flattener: the current piece's three points, a single
// adder that does every split, flatness and rounding step, and the second
// half produced by the last split.
// ----------------------------------------------------------------------------
module cbf_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  cbf_pkg::lane_op_t                  op,
  input  cbf_pkg::coord_t                    ld_p1,
  input  cbf_pkg::coord_t                    ld_p2,
  input  cbf_pkg::coord_t                    ld_p3,
  input  logic [cbf_pkg::LIM_W-1:0]          flat_limit,
  input  cbf_pkg::acc_t                      neg_limit,
  output logic                               flat,
  output cbf_pkg::pix_t                      pix,
  output cbf_pkg::coord_t                    half_p1,
  output cbf_pkg::coord_t                    half_p2,
  output cbf_pkg::coord_t                    half_p3
);
  import cbf_pkg::*;

  localparam acc_t HALF = {{(AW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  coord_t a, b, c;
  acc_t   t0, t1, t2, t3;
  acc_t   opa, opb, res, shifted, lim;
  logic   sub;

  // Operand selection for the shared adder.
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    case (op)
      OP_CHECK: begin
        opa = ext_coord(c);
        opb = ext_coord(b);
        sub = 1'b1;
      end
      OP_PIX: begin
        opa = ext_coord(c);
        opb = HALF;
      end
      OP_AB: begin
        opa = ext_coord(a);
        opb = ext_coord(b);
      end
      OP_BC: begin
        opa = ext_coord(b);
        opb = ext_coord(c);
      end
      OP_A2B: begin
        opa = ext_coord(a);
        opb = t0;
      end
      OP_ABC: begin
        opa = t0;
        opb = t1;
      end
      OP_MID: begin
        opa = t2;
        opb = t0;
      end
      OP_S1: begin
        opa = t0 >>> 2;
        opb = t3;
        sub = 1'b1;
      end
      OP_S2: begin
        opa = t1 >>> 1;
        opb = t3;
        sub = 1'b1;
      end
      OP_S3: begin
        opa = ext_coord(c);
        opb = t3;
        sub = 1'b1;
      end
      default: begin
        opa = '0;
        opb = '0;
        sub = 1'b0;
      end
    endcase
  end

  assign res = opa + (opb ^ {AW{sub}}) + {{(AW-1){1'b0}}, sub};

  // Both legs of this axis must lie within the limit; the last leg comes
  // from the adder during the check step.
  assign lim  = {{(AW-LIM_W){1'b0}}, flat_limit};
  assign flat = (ext_coord(a) <= lim) && (ext_coord(a) >= neg_limit) &&
                (res <= lim) && (res >= neg_limit);

  assign shifted = res >>> FRAC_BITS;

  always_comb begin
    if (shifted > PIX_HI) begin
      pix = PIX_HI[PIX_W-1:0];
    end else if (shifted < PIX_LO) begin
      pix = PIX_LO[PIX_W-1:0];
    end else begin
      pix = shifted[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        a <= ld_p1;
        b <= ld_p2;
        c <= ld_p3;
      end
      OP_AB:  t0 <= res;
      OP_BC:  t1 <= res;
      OP_A2B: t2 <= res;
      OP_ABC: t0 <= res;
      OP_MID: t3 <= res >>> 3;
      OP_S1:  half_p1 <= res[CW-1:0];
      OP_S2:  half_p2 <= res[CW-1:0];
      OP_S3: begin
        // The current piece becomes the first half.
        half_p3 <= res[CW-1:0];
        a       <= a >>> 1;
        b       <= t2[CW+1:2];
        c       <= t3[CW-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== dv/cbf_step_checker.sv =====
// ----------------------------------------------------------------------------
// cbf_step_checker
// Watches the curve, step and configuration ports of the flattener. It keeps
// its own copy of flat_limit, subdivides every accepted curve itself and
// compares each delivered pixel step with the oldest predicted one.
// ----------------------------------------------------------------------------
module cbf_step_checker #(
  parameter int MAX_DEPTH = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  cbf_pkg::in_coord_t         ctrl1_x,
  input  cbf_pkg::in_coord_t         ctrl1_y,
  input  cbf_pkg::in_coord_t         ctrl2_x,
  input  cbf_pkg::in_coord_t         ctrl2_y,
  input  cbf_pkg::in_coord_t         end_x,
  input  cbf_pkg::in_coord_t         end_y,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  cbf_pkg::pix_t              step_dx,
  input  cbf_pkg::pix_t              step_dy,
  input  logic                       last_step,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbf_pkg::ADDR_W-1:0] paddr,
  input  logic [cbf_pkg::DATA_W-1:0] pwdata,
  input  logic [cbf_pkg::DATA_W-1:0] prdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         steps_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbf_pkg::*;

  localparam acc_t PIXEL_MAX = 32767;
  localparam acc_t PIXEL_MIN = -32768;

  typedef struct {
    coord_t p1x, p1y, p2x, p2y, p3x, p3y;
    int     level;
  } piece_t;

  typedef struct {
    pix_t dx;
    pix_t dy;
    logic last;
  } step_t;

  logic [LIM_W-1:0] flat_limit;
  step_t            pixel_steps[$];
  int               errors = 0;

  assign fail_count = errors;

  function automatic acc_t magnitude(input acc_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic piece_is_flat(input piece_t pc);
    acc_t lim;
    lim = {{(AW-LIM_W){1'b0}}, flat_limit};
    return pc.level >= MAX_DEPTH ||
           (magnitude(acc_t'(pc.p1x)) <= lim && magnitude(acc_t'(pc.p1y)) <= lim &&
            magnitude(acc_t'(pc.p3x) - acc_t'(pc.p2x)) <= lim &&
            magnitude(acc_t'(pc.p3y) - acc_t'(pc.p2y)) <= lim);
  endfunction

  // Round half up to whole pixels, then clamp to the 16-bit delta range.
  function automatic pix_t to_pixel(input coord_t v);
    acc_t p;
    p = (acc_t'(v) + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (p > PIXEL_MAX) p = PIXEL_MAX;
    else if (p < PIXEL_MIN) p = PIXEL_MIN;
    return pix_t'(p);
  endfunction

  // De Casteljau split at t = 1/2 of one axis; the second half is taken
  // relative to the midpoint. Every shift floors.
  function automatic void halve_axis(input coord_t a, input coord_t b, input coord_t c,
                                     output coord_t f1, output coord_t f2,
                                     output coord_t fm, output coord_t s1,
                                     output coord_t s2, output coord_t s3);
    acc_t ab, bc, a2b, abc, mid;
    ab  = acc_t'(a) + acc_t'(b);
    bc  = acc_t'(b) + acc_t'(c);
    a2b = acc_t'(a) + ab;
    abc = ab + bc;
    mid = (a2b + abc) >>> 3;
    f1  = coord_t'(acc_t'(a) >>> 1);
    f2  = coord_t'(a2b >>> 2);
    fm  = coord_t'(mid);
    s1  = coord_t'((abc >>> 2) - mid);
    s2  = coord_t'((bc >>> 1) - mid);
    s3  = coord_t'(acc_t'(c) - mid);
  endfunction

  function automatic void flatten_curve(input in_coord_t c1x, input in_coord_t c1y,
                                        input in_coord_t c2x, input in_coord_t c2y,
                                        input in_coord_t ex, input in_coord_t ey);
    piece_t cur, first, second;
    piece_t pending [MAX_DEPTH+1];
    int     depth_sp;
    step_t  st;
    cur.p1x   = coord_t'(c1x);
    cur.p1y   = coord_t'(c1y);
    cur.p2x   = coord_t'(c2x);
    cur.p2y   = coord_t'(c2y);
    cur.p3x   = coord_t'(ex);
    cur.p3y   = coord_t'(ey);
    cur.level = 0;
    depth_sp  = 0;
    while (1) begin
      if (piece_is_flat(cur)) begin
        st.dx   = to_pixel(cur.p3x);
        st.dy   = to_pixel(cur.p3y);
        st.last = (depth_sp == 0);
        pixel_steps.push_back(st);
        if (depth_sp == 0) break;
        depth_sp--;
        cur = pending[depth_sp];
      end else begin
        halve_axis(cur.p1x, cur.p2x, cur.p3x, first.p1x, first.p2x, first.p3x,
                   second.p1x, second.p2x, second.p3x);
        halve_axis(cur.p1y, cur.p2y, cur.p3y, first.p1y, first.p2y, first.p3y,
                   second.p1y, second.p2y, second.p3y);
        first.level  = cur.level + 1;
        second.level = first.level;
        if (depth_sp < MAX_DEPTH + 1) begin
          pending[depth_sp] = second;
          depth_sp++;
        end
        cur = first;
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    step_t want;
    if (rst) begin
      flat_limit = FLAT_LIMIT_RST;
      pixel_steps.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[ADDR_W-1:2] == REG_FLAT_LIMIT) flat_limit = pwdata[LIM_W-1:0];
        end else if (paddr[ADDR_W-1:2] == REG_FLAT_LIMIT &&
                     prdata !== DATA_W'(flat_limit)) begin
          $error("flat_limit: expected %0d, actual %0d", flat_limit, prdata);
          errors++;
        end
      end
      if (in_valid && !in_stall) begin
        flatten_curve(ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y);
      end
      if (out_valid && !out_stall) begin
        if (pixel_steps.size() == 0) begin
          $error("unpredicted step: step_dx %0d, step_dy %0d, last_step %0b",
                 step_dx, step_dy, last_step);
          errors++;
        end else begin
          want = pixel_steps.pop_front();
          if (step_dx !== want.dx) begin
            $error("step_dx: expected %0d, actual %0d", want.dx, step_dx);
            errors++;
          end
          if (step_dy !== want.dy) begin
            $error("step_dy: expected %0d, actual %0d", want.dy, step_dy);
            errors++;
          end
          if (last_step !== want.last) begin
            $error("last_step: expected %0b, actual %0b", want.last, last_step);
            errors++;
          end
        end
      end
    end
    steps_due <= pixel_steps.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression for cubic_bezier_flattener_core: directed corner curves, then
// random curves under several flatness limits, with random idling on both
// channels, a long output hold-off and a full drain. Checking is done by
// cbf_step_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbf_pkg::*;

  localparam int     MAX_DEPTH    = 6;
  localparam int     FRAC_BITS    = 16;
  localparam int     PERIOD       = 10;
  localparam int     CURVE_CYCLES = 10 * (2**MAX_DEPTH - 1) + 3 * (2**MAX_DEPTH) + 1;
  localparam int     HOLD_CYCLES  = 600;
  localparam int     QUIET_ITEMS  = 60;
  localparam longint LIMIT_NS     = 50_000_000;

  localparam in_coord_t C_MAX   = 32'sh7FFF_FFFF;
  localparam in_coord_t C_MIN   = 32'sh8000_0000;
  localparam in_coord_t HALF_PX = 32'sh0000_8000;
  localparam in_coord_t ONE_PX  = 32'sh0001_0000;
  localparam in_coord_t LIM_RST = in_coord_t'(FLAT_LIMIT_RST);
  localparam in_coord_t CORNERS [6] = '{C_MAX, C_MIN, 0, -1, 1, HALF_PX};

  localparam logic [ADDR_W-1:0] ADDR_FLAT_LIMIT = {REG_FLAT_LIMIT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED   = ADDR_W'(4);
  localparam logic APB_WRITE = 1'b1;
  localparam logic APB_READ  = 1'b0;

  typedef enum int {
    PH_RESET_LIMIT,
    PH_ZERO_LIMIT,
    PH_FULL_LIMIT,
    PH_RANDOM_LIMIT,
    PH_SMALL_LIMIT
  } phase_e;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall;
  in_coord_t ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y;
  logic out_valid, out_stall;
  pix_t step_dx, step_dy;
  logic last_step;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int   fail_count, steps_due;
  bit   hold_on = 1'b0;
  bit   quiet = 1'b0;

  always #(PERIOD / 2) clk = ~clk;

  cubic_bezier_flattener_core #(
    .MAX_DEPTH(MAX_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) dut (.*);

  cbf_step_checker #(
    .MAX_DEPTH(MAX_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (.*);

  // Offers one curve request, holds it until taken, then sometimes idles.
  task automatic send_curve(input in_coord_t c1x, input in_coord_t c1y,
                            input in_coord_t c2x, input in_coord_t c2y,
                            input in_coord_t ex, input in_coord_t ey);
    ctrl1_x  <= c1x;
    ctrl1_y  <= c1y;
    ctrl2_x  <= c2x;
    ctrl2_y  <= c2y;
    end_x    <= ex;
    end_y    <= ey;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain_steps();
    in_valid <= 1'b0;
    do @(posedge clk); while (steps_due != 0 || in_stall);
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_coord_t rand_scaled(input longint base, input int k);
    longint bound, v;
    bound = base <<< k;
    if (bound > 64'sh7FFF_FFFF) bound = 64'sh7FFF_FFFF;
    v = longint'($urandom) % (bound + 1);
    if ($urandom_range(0, 1) == 1) v = -v;
    return in_coord_t'(v);
  endfunction

  // Output side: random stall bursts, one long hold-off on request, and no
  // stalls at all once the run goes quiet.
  initial begin : receiver
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_on) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("cubic_bezier_flattener_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    phase_e           ph;
    logic [LIM_W-1:0] lim;
    int               count, k, kind;
    longint           base;
    in_coord_t        v [6];

    rst      <= 1'b1;
    in_valid <= 1'b0;
    ctrl1_x  <= '0;
    ctrl1_y  <= '0;
    ctrl2_x  <= '0;
    ctrl2_y  <= '0;
    end_x    <= '0;
    end_y    <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed curves under the reset limit.
    send_curve(0, 0, 0, 0, 0, 0);
    send_curve(0, 0, ONE_PX, 0, ONE_PX, 0);
    send_curve(0, 0, HALF_PX, -HALF_PX, HALF_PX, -HALF_PX);
    send_curve(0, 0, 32'sh17FFF, 32'sh18000, 32'sh17FFF, 32'sh18000);
    send_curve(LIM_RST, -LIM_RST, 0, 0, 0, 0);
    send_curve(LIM_RST + 1, 0, 0, 0, 0, 0);
    send_curve(0, 0, 0, -LIM_RST, 0, 0);
    send_curve(0, 0, 0, -(LIM_RST + 1), 0, 0);
    send_curve(0, 0, C_MAX, C_MAX, C_MAX, C_MAX);
    send_curve(0, 0, C_MIN, C_MIN, C_MIN, C_MIN);
    send_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
    send_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_curve(-1, -3, -5, -7, -9, -11);
    send_curve(-LIM_RST - 1, -1, -3, LIM_RST + 3, -32'sh30001, 32'sh2FFFF);
    send_curve(32'sh100000, 0, 32'sh100000, 32'sh80000, 32'sh100000, 32'sh100000);
    send_curve(32'sh200000, -32'sh200000, -32'sh200000, 32'sh200000, 0, 0);
    send_curve(C_MAX, 0, 0, C_MAX, C_MAX, C_MAX);
    send_curve(1, 1, 1, 1, 1, 1);
    send_curve(32'sh18000, -32'sh18000, 32'sh28000, -32'sh28000, 32'sh40000, -32'sh40000);
    send_curve(-32'sh7FFF, 32'sh7FFF, -32'sh48001, 32'sh48001, -32'sh4FFFF, 32'sh3FFFF);

    // Reset value read back, then a write to an unmapped register that must
    // leave flat_limit alone.
    drain_steps();
    apb_access(APB_READ, ADDR_FLAT_LIMIT, '0);
    apb_access(APB_WRITE, ADDR_UNMAPPED, $urandom);
    apb_access(APB_READ, ADDR_FLAT_LIMIT, '0);

    for (int p = 0; p <= int'(PH_SMALL_LIMIT); p++) begin
      ph = phase_e'(p);
      case (ph)
        PH_RESET_LIMIT: begin
          lim   = FLAT_LIMIT_RST;
          count = 130;
        end
        PH_ZERO_LIMIT: begin
          lim   = '0;
          count = 20;
        end
        PH_FULL_LIMIT: begin
          lim   = '1;
          count = 45;
        end
        PH_RANDOM_LIMIT: begin
          lim   = LIM_W'($urandom);
          lim   = lim >> $urandom_range(0, LIM_W - 1);
          count = 130;
        end
        default: begin
          lim   = LIM_W'($urandom_range(16, 65536));
          count = 130;
        end
      endcase
      drain_steps();
      apb_access(APB_WRITE, ADDR_FLAT_LIMIT, {1'($urandom), lim});
      apb_access(APB_READ, ADDR_FLAT_LIMIT, '0);
      base = (lim == 0) ? 4096 : longint'(lim);

      for (int i = 0; i < count; i++) begin
        // Requests keep coming through the hold-off, so the block backs up
        // and stalls its input.
        if (ph == PH_RESET_LIMIT && i == 10) hold_on = 1'b1;
        if (ph == PH_RANDOM_LIMIT && i == 50) drain_steps();
        if (ph == PH_SMALL_LIMIT && i >= count - QUIET_ITEMS) quiet = 1'b1;

        // Mostly curves sized around the limit so that the split depth varies,
        // plus full-range noise, near-flat curves and corner values.
        k    = $urandom_range(0, 6);
        kind = $urandom_range(0, 99);
        for (int j = 0; j < 6; j++) begin
          if (kind < 60) v[j] = rand_scaled(base, (j < 2) ? k : k + 1);
          else if (kind < 75) v[j] = $urandom;
          else if (kind < 88) v[j] = rand_scaled(base, 0);
          else v[j] = CORNERS[$urandom_range(0, 5)];
        end
        send_curve(v[0], v[1], v[2], v[3], v[4], v[5]);
      end
    end

    drain_steps();
    repeat (CURVE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("cubic_bezier_flattener_core regression: pass");
    end else begin
      $display("cubic_bezier_flattener_core regression: fail");
    end
    $finish;
  end

endmodule
